FILE: rtl/psdrc_pkg.sv
// ----------------------------------------------------------------------------
// psdrc_pkg
// Shared types and constants of the per-source drain rate controller.
// ----------------------------------------------------------------------------
package psdrc_pkg;

  localparam int MaxSources = 16;
  localparam int SlotW      = 4;
  localparam int LevelW     = 24;
  localparam int DurW       = 16;
  localparam int RatioW     = 18;
  localparam int FactorW    = 16;
  localparam int DivW       = 41;
  localparam int AddrW      = 5;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_STALE  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_SMOOTHING = 3'd1;
  localparam logic [2:0] REG_TARGET    = 3'd2;
  localparam logic [2:0] REG_TOLERANCE = 3'd3;
  localparam logic [2:0] REG_SPEEDUP   = 3'd4;

  localparam logic [RatioW-1:0] ONE_Q16       = 18'd65536;
  localparam logic [RatioW-1:0] RATIO_DEADBAND = 18'd6;
  localparam logic [DivW-1:0]   MIN_TARGET_BLK = 41'd131072;
  localparam logic [DivW-1:0]   MIN_TOL_BLK    = 41'd65536;
  localparam logic [DurW-1:0]   PERCENT_DIV    = 16'd100;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_STALE,
    KIND_REMOVE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SlotW-1:0]  slot;
    logic [LevelW-1:0] backlog;
    logic [DurW-1:0]   dur;
  } item_t;

endpackage

FILE: rtl/per_source_drain_rate_controller.sv
// ----------------------------------------------------------------------------
// per_source_drain_rate_controller
// Per-slot smoothed backlog and drain ratio commands.
// ----------------------------------------------------------------------------
// channel  | handshake          | beat
// in       | in_valid/in_stall  | opcode, source_slot, backlog, block_duration
// out      | out_valid/out_stall| cmd_slot, drain_ratio, smoothed_backlog
// cfg      | APB psel/penable   | paddr, pwdata, prdata
//
// A sample runs the multiply and sum steps, then up to four passes of the shared
// divider (level, target, tolerance, percent); the percent pass only above the band.
// Stale and remove items just clear valid bits. A two-beat queue sits in front.
// Reset is synchronous; slot valid bits clear at once.
// A stalled result blocks the back only when another result is ready.
// ----------------------------------------------------------------------------
module per_source_drain_rate_controller
  import psdrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [SlotW-1:0]  source_slot,
  input  logic [LevelW-1:0] backlog,
  input  logic [DurW-1:0]   block_duration,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SlotW-1:0]  cmd_slot,
  output logic [RatioW-1:0] drain_ratio,
  output logic [LevelW-1:0] smoothed_backlog,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic               enable;
  logic [FactorW-1:0] smoothing_factor;
  logic [LevelW-1:0]  target_level;
  logic [LevelW-1:0]  tolerance_level;
  logic [RatioW-1:0]  max_speedup;
  logic               push;
  item_t              push_item;
  item_t              head;
  logic               empty;
  logic               full;
  logic               pop;

  assign pready   = 1'b1;
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b1;
      smoothing_factor <= 16'd58982;
      target_level     <= 24'd10240;
      tolerance_level  <= 24'd5120;
      max_speedup      <= 18'd78643;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_ENABLE:    enable           <= pwdata[0];
        REG_SMOOTHING: smoothing_factor <= pwdata[FactorW-1:0];
        REG_TARGET:    target_level     <= pwdata[LevelW-1:0];
        REG_TOLERANCE: tolerance_level  <= pwdata[LevelW-1:0];
        REG_SPEEDUP:   max_speedup      <= pwdata[RatioW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:    prdata = {31'h0, enable};
      REG_SMOOTHING: prdata = {16'h0, smoothing_factor};
      REG_TARGET:    prdata = {8'h0, target_level};
      REG_TOLERANCE: prdata = {8'h0, tolerance_level};
      REG_SPEEDUP:   prdata = {14'h0, max_speedup};
      default:       prdata = 32'h0;
    endcase
  end

  psdrc_front u_front (
    .enable         (enable),
    .in_valid       (in_valid),
    .opcode         (opcode),
    .source_slot    (source_slot),
    .backlog        (backlog),
    .block_duration (block_duration),
    .q_full         (full),
    .push           (push),
    .push_item      (push_item)
  );

  psdrc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  psdrc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .smoothing_factor (smoothing_factor),
    .target_level     (target_level),
    .tolerance_level  (tolerance_level),
    .max_speedup      (max_speedup),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cmd_slot         (cmd_slot),
    .drain_ratio      (drain_ratio),
    .smoothed_backlog (smoothed_backlog)
  );

endmodule

FILE: rtl/psdrc_front.sv
// ----------------------------------------------------------------------------
// psdrc_front
// Takes input beats, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
module psdrc_front
  import psdrc_pkg::*;
(
  input  logic              enable,
  input  logic              in_valid,
  input  logic [1:0]        opcode,
  input  logic [SlotW-1:0]  source_slot,
  input  logic [LevelW-1:0] backlog,
  input  logic [DurW-1:0]   block_duration,
  input  logic              q_full,
  output logic              push,
  output item_t             push_item
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    push_item.kind = KIND_SAMPLE;
    unique case (opcode)
      OP_SAMPLE: begin
        keep = enable && (block_duration != '0);
      end
      OP_STALE: begin
        keep = 1'b1;
        push_item.kind = KIND_STALE;
      end
      OP_REMOVE: begin
        keep = 1'b1;
        push_item.kind = KIND_REMOVE;
      end
      default: keep = 1'b0;
    endcase
    push_item.slot    = source_slot;
    push_item.backlog = backlog;
    push_item.dur     = block_duration;
  end

  assign push = in_valid && !q_full && keep;

endmodule

FILE: rtl/psdrc_fifo.sv
// ----------------------------------------------------------------------------
// psdrc_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module psdrc_fifo
  import psdrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/psdrc_div.sv
// ----------------------------------------------------------------------------
// psdrc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psdrc_div
  import psdrc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [DurW-1:0] divisor,
  output logic            done,
  output logic [DivW-1:0] quotient
);

  logic [DurW-1:0] dsr;
  logic [DurW-1:0] rem;
  logic [DivW-1:0] quo;
  logic [5:0]      cnt;
  logic            busy;
  logic [DurW:0]   trial;
  logic            fits;

  assign trial    = {rem, quo[DivW-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dsr  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? DurW'(trial - {1'b0, dsr}) : trial[DurW-1:0];
        quo <= {quo[DivW-2:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/psdrc_back.sv
// ----------------------------------------------------------------------------
// psdrc_back
// Runs queued items: slot table, smoothing, block conversion, ratio, output.
// ----------------------------------------------------------------------------
module psdrc_back
  import psdrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [FactorW-1:0] smoothing_factor,
  input  logic [LevelW-1:0]  target_level,
  input  logic [LevelW-1:0]  tolerance_level,
  input  logic [RatioW-1:0]  max_speedup,
  input  item_t              head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SlotW-1:0]   cmd_slot,
  output logic [RatioW-1:0]  drain_ratio,
  output logic [LevelW-1:0]  smoothed_backlog
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUM, S_DIV_S, S_DIV_T, S_DIV_L,
    S_BAND, S_DIV_R, S_CAP, S_DECIDE, S_EMIT
  } state_t;

  state_t             state;
  logic               smooth_valid [MaxSources];
  logic               ratio_valid  [MaxSources];
  logic [LevelW-1:0]  smoothed_level [MaxSources];
  logic [RatioW-1:0]  last_ratio [MaxSources];

  logic [SlotW-1:0]   slot;
  logic [LevelW-1:0]  smp;
  logic [LevelW-1:0]  prev;
  logic [DurW-1:0]    dur;
  logic [39:0]        prod1;
  logic [40:0]        prod2;
  logic [LevelW-1:0]  smoothed;
  logic [DivW-1:0]    blocks;
  logic [DivW-1:0]    tb;
  logic [DivW-1:0]    band;
  logic [RatioW-1:0]  ratio;
  logic               div_start;
  logic [DivW-1:0]    div_dividend;
  logic [DurW-1:0]    div_divisor;
  logic               div_done;
  logic [DivW-1:0]    div_q;
  logic [DivW+1:0]    raised;
  logic [RatioW-1:0]  base_ratio;
  logic [RatioW-1:0]  diff;
  logic [DivW-1:0]    lb_c;

  psdrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pop        = (state == S_IDLE) && !empty;
  assign raised     = {2'b0, div_q} + 43'(ONE_Q16);
  assign base_ratio = ratio_valid[slot] ? last_ratio[slot] : ONE_Q16;
  assign diff       = (ratio > base_ratio) ? ratio - base_ratio : base_ratio - ratio;
  assign lb_c       = (div_q < MIN_TOL_BLK) ? MIN_TOL_BLK : div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      for (int i = 0; i < MaxSources; i++) begin
        smooth_valid[i] <= 1'b0;
        ratio_valid[i]  <= 1'b0;
      end
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            slot <= head.slot;
            smp  <= head.backlog;
            dur  <= head.dur;
            prev <= smooth_valid[head.slot] ? smoothed_level[head.slot] : head.backlog;
            case (head.kind)
              KIND_STALE: smooth_valid[head.slot] <= 1'b0;
              KIND_REMOVE: begin
                smooth_valid[head.slot] <= 1'b0;
                ratio_valid[head.slot]  <= 1'b0;
              end
              default: state <= S_MUL1;
            endcase
          end
        end
        S_MUL1: begin
          prod1 <= prev * smoothing_factor;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod2 <= smp * (17'h10000 - {1'b0, smoothing_factor});
          state <= S_SUM;
        end
        S_SUM: begin
          smoothed             <= LevelW'(({1'b0, prod1} + prod2) >> 16);
          smoothed_level[slot] <= LevelW'(({1'b0, prod1} + prod2) >> 16);
          smooth_valid[slot]   <= 1'b1;
          div_dividend <= {1'b0, LevelW'(({1'b0, prod1} + prod2) >> 16), 16'h0};
          div_divisor  <= dur;
          div_start    <= 1'b1;
          state        <= S_DIV_S;
        end
        S_DIV_S: begin
          if (div_done) begin
            blocks       <= div_q;
            div_dividend <= {1'b0, target_level, 16'h0};
            div_start    <= 1'b1;
            state        <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (div_done) begin
            tb           <= (div_q < MIN_TARGET_BLK) ? MIN_TARGET_BLK : div_q;
            div_dividend <= {1'b0, tolerance_level, 16'h0};
            div_start    <= 1'b1;
            state        <= S_DIV_L;
          end
        end
        S_DIV_L: begin
          if (div_done) begin
            band  <= tb + lb_c;
            state <= S_BAND;
          end
        end
        S_BAND: begin
          if (blocks <= band) begin
            ratio <= ONE_Q16;
            state <= S_DECIDE;
          end else begin
            div_dividend <= blocks - band;
            div_divisor  <= PERCENT_DIV;
            div_start    <= 1'b1;
            state        <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) state <= S_CAP;
        end
        S_CAP: begin
          ratio <= (raised > {25'h0, max_speedup}) ? max_speedup : raised[RatioW-1:0];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= (diff > RATIO_DEADBAND) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            last_ratio[slot]  <= ratio;
            ratio_valid[slot] <= 1'b1;
            out_valid         <= 1'b1;
            cmd_slot          <= slot;
            drain_ratio       <= ratio;
            smoothed_backlog  <= smoothed;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
